>>> rtl/ocf_pkg.sv
// ----------------------------------------------------------------------------
// ocf_pkg
// Shared widths, codes and saturation helper for the overlap crossover finder.
// ----------------------------------------------------------------------------
`default_nettype none

package ocf_pkg;

  localparam int MAX_OVERLAP = 4096;
  localparam int SYMBOL_BITS = 4;
  localparam int SCORE_BITS  = 16;
  localparam int ADDR_BITS   = 2 * SYMBOL_BITS;
  localparam int TABLE_DEPTH = 1 << ADDR_BITS;
  localparam int SUM_BITS    = 30;
  localparam int WIDE_BITS   = SUM_BITS + 2;
  localparam int POS_BITS    = 13;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_COLUMN = 1'b1;

  localparam logic signed [WIDE_BITS-1:0] SUM_MAX = WIDE_BITS'((64'sd1 <<< (SUM_BITS - 1)) - 1);
  localparam logic signed [WIDE_BITS-1:0] SUM_MIN = WIDE_BITS'(-(64'sd1 <<< (SUM_BITS - 1)));

  typedef logic signed [SCORE_BITS-1:0] score_t;
  typedef logic signed [SUM_BITS-1:0]   sum_t;
  typedef logic signed [WIDE_BITS-1:0]  wide_t;
  typedef logic [POS_BITS-1:0]          pos_t;

  function automatic sum_t sat_sum(input wide_t v);
    sum_t r;
    if (v > SUM_MAX) begin
      r = SUM_MAX[SUM_BITS-1:0];
    end else if (v < SUM_MIN) begin
      r = SUM_MIN[SUM_BITS-1:0];
    end else begin
      r = v[SUM_BITS-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/overlap_crossover_finder.sv
// ----------------------------------------------------------------------------
// overlap_crossover_finder
// A last column is registered with its table reads in the first stage, and
// its result word is registered as that column passes the second stage.
// Throughput: one item per cycle; the score table read is the first stage,
// the add, saturate and compare on the running sums the second. A last
// column waits in the first stage while the previous result word is stalled.
// Reset clears the accumulators, count, flag and valids; the score table is
// not cleared and must be loaded before use.
// ----------------------------------------------------------------------------
`default_nettype none

module overlap_crossover_finder (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           item_valid,
  output logic                                item_stall,
  input  wire logic                           cmd,
  input  wire logic [3:0]                     left_query,
  input  wire logic [3:0]                     left_target,
  input  wire logic [3:0]                     right_query,
  input  wire logic [3:0]                     right_target,
  input  wire logic                           last_column,
  input  wire logic [3:0]                     entry_row,
  input  wire logic [3:0]                     entry_col,
  input  wire logic signed [15:0]             entry_score,
  output logic                                result_valid,
  input  wire logic                           result_stall,
  output ocf_pkg::pos_t                       crossover_pos,
  output ocf_pkg::sum_t                       score_adjustment,
  output ocf_pkg::pos_t                       overlap_length,
  output logic                                overlap_too_long
);

  ocf_pkg::score_t mem [ocf_pkg::TABLE_DEPTH];

  logic            accept;
  logic            s1_valid;
  logic            s1_last;
  ocf_pkg::score_t left_score;
  ocf_pkg::score_t right_score;
  logic            out_free;
  logic            fire;
  logic            s1_move;

  ocf_pkg::sum_t running_diff, running_diff_next;
  ocf_pkg::sum_t best_diff, best_diff_next;
  ocf_pkg::pos_t best_position, best_position_next;
  ocf_pkg::sum_t left_sum, left_sum_next;
  ocf_pkg::pos_t column_count, column_count_next;
  logic          too_long_flag, too_long_flag_next;
  ocf_pkg::sum_t adjust;

  assign out_free   = !result_valid || !result_stall;
  assign fire       = s1_valid && (!s1_last || out_free);
  assign s1_move    = !s1_valid || fire;
  assign item_stall = !s1_move;
  assign accept     = item_valid && s1_move;

  // table write on load, two registered reads on column
  always_ff @(posedge clk) begin
    if (accept && cmd == ocf_pkg::CMD_LOAD) begin
      mem[{entry_row[ocf_pkg::SYMBOL_BITS-1:0], entry_col[ocf_pkg::SYMBOL_BITS-1:0]}] <=
        ocf_pkg::SCORE_BITS'(entry_score);
    end
    if (accept && cmd == ocf_pkg::CMD_COLUMN) begin
      left_score  <= mem[{left_query[ocf_pkg::SYMBOL_BITS-1:0],
                          left_target[ocf_pkg::SYMBOL_BITS-1:0]}];
      right_score <= mem[{right_query[ocf_pkg::SYMBOL_BITS-1:0],
                          right_target[ocf_pkg::SYMBOL_BITS-1:0]}];
      s1_last     <= last_column;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_move) begin
      s1_valid <= accept && cmd == ocf_pkg::CMD_COLUMN;
    end
  end

  always_comb begin
    running_diff_next  = running_diff;
    best_diff_next     = best_diff;
    best_position_next = best_position;
    left_sum_next      = left_sum;
    column_count_next  = column_count;
    too_long_flag_next = too_long_flag;
    if (column_count == ocf_pkg::POS_BITS'(ocf_pkg::MAX_OVERLAP)) begin
      too_long_flag_next = 1'b1;
    end else begin
      left_sum_next     = ocf_pkg::sat_sum(ocf_pkg::wide_t'(left_sum) +
                                           ocf_pkg::wide_t'(left_score));
      running_diff_next = ocf_pkg::sat_sum(ocf_pkg::wide_t'(running_diff) +
                                           ocf_pkg::wide_t'(left_score) -
                                           ocf_pkg::wide_t'(right_score));
      column_count_next = column_count + 1'b1;
      if (running_diff_next > best_diff) begin
        best_diff_next     = running_diff_next;
        best_position_next = column_count_next;
      end
    end
    adjust = ocf_pkg::sat_sum(ocf_pkg::wide_t'(left_sum_next) -
                              ocf_pkg::wide_t'(best_diff_next));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_diff  <= '0;
      best_diff     <= '0;
      best_position <= '0;
      left_sum      <= '0;
      column_count  <= '0;
      too_long_flag <= 1'b0;
    end else if (fire) begin
      if (s1_last) begin
        running_diff  <= '0;
        best_diff     <= '0;
        best_position <= '0;
        left_sum      <= '0;
        column_count  <= '0;
        too_long_flag <= 1'b0;
      end else begin
        running_diff  <= running_diff_next;
        best_diff     <= best_diff_next;
        best_position <= best_position_next;
        left_sum      <= left_sum_next;
        column_count  <= column_count_next;
        too_long_flag <= too_long_flag_next;
      end
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (fire && s1_last) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && s1_last) begin
      crossover_pos    <= best_position_next;
      score_adjustment <= adjust;
      overlap_length   <= column_count_next;
      overlap_too_long <= too_long_flag_next;
    end
  end

endmodule

`default_nettype wire
